@@ rtl/psa_pkg.sv @@
// Shared types, constants and the interval timer function of the sensor averager.
// Used by psa_ctrl, psa_dpath, psa_div_lane and periodic_sensor_averager_top; no dependencies.
package psa_pkg;

    // Field widths
    localparam int TIME_W   = 32;
    localparam int TEMP_W   = 15;
    localparam int PRES_W   = 17;
    localparam int HUM_W    = 17;
    localparam int MOIST_W  = 13;
    localparam int COUNT_W  = 16;

    // Accumulator widths
    localparam int TSUM_W   = 32;
    localparam int PSUM_W   = 33;
    localparam int HSUM_W   = 33;
    localparam int MSUM_W   = 29;

    // Divider: one quotient bit per step over the widest dividend
    localparam int DVD_W     = 33;
    localparam int DIV_STEPS = DVD_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // Stream and configuration port widths
    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 80;
    localparam int M_TUSER_W = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPORT_INTERVAL = 2'd1;

    // Constants
    localparam logic [COUNT_W-1:0] MAX_SAMPLES     = 16'd65535;
    localparam logic [MOIST_W-1:0] MOIST_ONE       = 13'd4096;
    localparam logic [TIME_W-1:0]  SAMPLE_INT_RST  = 32'd1000;
    localparam logic [TIME_W-1:0]  REPORT_INT_RST  = 32'd60000;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic timer_step;
        logic accum_step;
        logic div_load;
        logic div_step;
        logic out_load;
    } ctrl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic report_fire;
        logic count_zero;
    } dp_status_t;

    typedef struct packed {
        logic              fire;
        logic [TIME_W-1:0] next_start;
    } timer_res_t;

    // Fire when the elapsed time reaches the interval; advance the start, never below now
    function automatic timer_res_t timer_eval(input logic [TIME_W-1:0] start,
                                              input logic [TIME_W-1:0] interval,
                                              input logic [TIME_W-1:0] now);
        timer_res_t        res;
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W-1:0] adv;
        elapsed        = now - start;
        adv            = start + interval;
        res.fire       = (elapsed >= interval);
        res.next_start = res.fire ? ((adv < now) ? now : adv) : start;
        return res;
    endfunction

endpackage

@@ rtl/psa_div_lane.sv @@
// One lane of the shared-step restoring divider: unsigned dividend over 16-bit count.
// Depends on psa_pkg for widths.
module psa_div_lane (
    input  logic                         aclk,
    input  logic                         load,
    input  logic                         step,
    input  logic [psa_pkg::DVD_W-1:0]    dividend,
    input  logic [psa_pkg::COUNT_W-1:0]  divisor,
    output logic [psa_pkg::DVD_W-1:0]    quotient
);
    import psa_pkg::*;

    logic [COUNT_W-1:0] rem_reg;
    logic [COUNT_W-1:0] rem_next;
    logic [DVD_W-1:0]   quo_reg;
    logic [DVD_W-1:0]   quo_next;
    logic [COUNT_W-1:0] dvs_reg;
    logic [COUNT_W:0]   shifted;
    logic [COUNT_W+1:0] trial;

    // Bring down the next dividend bit and try a subtract
    always_comb begin
        shifted  = {rem_reg, quo_reg[DVD_W-1]};
        trial    = {1'b0, shifted} - {2'b00, dvs_reg};
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (load) begin
            rem_next = '0;
            quo_next = dividend;
        end else if (step) begin
            if (!trial[COUNT_W+1]) begin
                rem_next = trial[COUNT_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[COUNT_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (load) begin
            dvs_reg <= divisor;
        end
    end

    assign quotient = quo_reg;

endmodule

@@ rtl/psa_ctrl.sv @@
// Sequencing state machine of the sensor averager: handshakes, timer, accumulate, divide.
// Depends on psa_pkg for the command and status structs.
module psa_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  psa_pkg::dp_status_t  status,
    output psa_pkg::ctrl_cmd_t   cmd
);
    import psa_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_TIMER = 3'd1;
    localparam logic [2:0] ST_ACCUM = 3'd2;
    localparam logic [2:0] ST_LOAD  = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              m_tvalid_reg;
    logic              m_tvalid_next;
    logic              out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    // Advance through the phases of one word
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_TIMER;
                end
            end
            ST_TIMER: begin
                cmd.timer_step = 1'b1;
                state_next     = ST_ACCUM;
            end
            ST_ACCUM: begin
                cmd.accum_step = 1'b1;
                state_next     = status.report_fire ? ST_LOAD : ST_DONE;
            end
            ST_LOAD: begin
                cmd.div_load = 1'b1;
                step_next    = '0;
                state_next   = status.count_zero ? ST_DONE : ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the result word until the receiver takes it
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

@@ rtl/psa_dpath.sv @@
// Datapath of the sensor averager: interval registers, timers, accumulators, dividers, result.
// Depends on psa_pkg and psa_div_lane.
module psa_dpath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_write,
    input  logic [psa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [psa_pkg::CFG_DAT_W-1:0]  cfg_data,
    input  logic [psa_pkg::S_TDATA_W-1:0]  s_tdata,
    input  psa_pkg::ctrl_cmd_t             cmd,
    output psa_pkg::dp_status_t            status,
    output logic [psa_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [psa_pkg::M_TUSER_W-1:0]  m_tuser
);
    import psa_pkg::*;

    // Configuration and run state
    logic [TIME_W-1:0]  sample_int_reg;
    logic [TIME_W-1:0]  report_int_reg;
    logic [TIME_W-1:0]  sample_start_reg;
    logic [TIME_W-1:0]  report_start_reg;
    logic               synced_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [TSUM_W-1:0]  tsum_reg;
    logic [PSUM_W-1:0]  psum_reg;
    logic [HSUM_W-1:0]  hsum_reg;
    logic [MSUM_W-1:0]  msum_reg;

    // Captured word
    logic [TIME_W-1:0]  now_reg;
    logic [TEMP_W-1:0]  temp_reg;
    logic [PRES_W-1:0]  pres_reg;
    logic [HUM_W-1:0]   hum_reg;
    logic [MOIST_W-1:0] moist_reg;

    // Per-word flags and report data
    logic               sample_fire_reg;
    logic               report_fire_reg;
    logic               sampled_reg;
    logic               empty_reg;
    logic               neg_reg;
    logic [COUNT_W-1:0] count_out_reg;

    // Result register
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TUSER_W-1:0] m_tuser_reg;

    logic [TIME_W-1:0]  in_now;
    logic [TEMP_W-1:0]  in_temp;
    logic [PRES_W-1:0]  in_pres;
    logic [HUM_W-1:0]   in_hum;
    logic [MOIST_W-1:0] in_moist_raw;
    logic [MOIST_W-1:0] in_moist_inv;
    logic [TIME_W-1:0]  sample_base;
    logic [TIME_W-1:0]  report_base;
    timer_res_t         sample_res;
    timer_res_t         report_res;
    logic               take_sample;
    logic [TSUM_W-1:0]  tsum_abs;
    logic [DVD_W-1:0]   q_temp;
    logic [DVD_W-1:0]   q_pres;
    logic [DVD_W-1:0]   q_hum;
    logic [DVD_W-1:0]   q_moist;
    logic [TEMP_W-1:0]  avg_temp;
    logic               has_avg;

    // Unpack the input word and invert moisture, clamped at full scale
    assign in_now       = s_tdata[31:0];
    assign in_temp      = s_tdata[46:32];
    assign in_pres      = s_tdata[63:47];
    assign in_hum       = s_tdata[80:64];
    assign in_moist_raw = s_tdata[93:81];
    assign in_moist_inv = (in_moist_raw > MOIST_ONE) ? '0 : (MOIST_ONE - in_moist_raw);

    // Load both starts from the first word of a run
    assign sample_base = synced_reg ? sample_start_reg : now_reg;
    assign report_base = synced_reg ? report_start_reg : now_reg;
    assign sample_res  = timer_eval(sample_base, sample_int_reg, now_reg);
    assign report_res  = timer_eval(report_base, report_int_reg, now_reg);

    assign take_sample = sample_fire_reg && (count_reg != MAX_SAMPLES);
    assign tsum_abs    = tsum_reg[TSUM_W-1] ? (~tsum_reg + 1'b1) : tsum_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            now_reg   <= in_now;
            temp_reg  <= in_temp;
            pres_reg  <= in_pres;
            hum_reg   <= in_hum;
            moist_reg <= in_moist_inv;
        end
        if (cmd.timer_step) begin
            sample_fire_reg <= sample_res.fire;
        end
        if (cmd.accum_step) begin
            sampled_reg <= take_sample;
            empty_reg   <= 1'b0;
        end
        if (cmd.div_load) begin
            empty_reg     <= (count_reg == '0);
            neg_reg       <= tsum_reg[TSUM_W-1];
            count_out_reg <= count_reg;
        end
        if (cmd.out_load) begin
            m_tdata_reg <= has_avg ? {2'b00, q_moist[MOIST_W-1:0], q_hum[HUM_W-1:0],
                                      q_pres[PRES_W-1:0], avg_temp, count_out_reg}
                                   : '0;
            m_tuser_reg <= {report_fire_reg && empty_reg, sampled_reg, report_fire_reg};
        end
    end

    // Run state: writes to the two interval registers restart the run
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_int_reg   <= SAMPLE_INT_RST;
            report_int_reg   <= REPORT_INT_RST;
            sample_start_reg <= '0;
            report_start_reg <= '0;
            synced_reg       <= 1'b0;
            report_fire_reg  <= 1'b0;
            count_reg        <= '0;
            tsum_reg         <= '0;
            psum_reg         <= '0;
            hsum_reg         <= '0;
            msum_reg         <= '0;
        end else if (cfg_write && (cfg_index == REG_SAMPLE_INTERVAL ||
                                   cfg_index == REG_REPORT_INTERVAL)) begin
            if (cfg_index == REG_SAMPLE_INTERVAL) begin
                sample_int_reg <= cfg_data;
            end else begin
                report_int_reg <= cfg_data;
            end
            synced_reg <= 1'b0;
            count_reg  <= '0;
            tsum_reg   <= '0;
            psum_reg   <= '0;
            hsum_reg   <= '0;
            msum_reg   <= '0;
        end else if (cmd.timer_step) begin
            sample_start_reg <= sample_res.next_start;
            report_start_reg <= report_res.next_start;
            report_fire_reg  <= report_res.fire;
            synced_reg       <= 1'b1;
        end else if (cmd.accum_step) begin
            if (take_sample) begin
                count_reg <= count_reg + 1'b1;
                tsum_reg  <= tsum_reg + {{(TSUM_W-TEMP_W){temp_reg[TEMP_W-1]}}, temp_reg};
                psum_reg  <= psum_reg + {{(PSUM_W-PRES_W){1'b0}}, pres_reg};
                hsum_reg  <= hsum_reg + {{(HSUM_W-HUM_W){1'b0}}, hum_reg};
                msum_reg  <= msum_reg + {{(MSUM_W-MOIST_W){1'b0}}, moist_reg};
            end
        end else if (cmd.div_load) begin
            // Clear the run once the sums are in the dividers
            count_reg <= '0;
            tsum_reg  <= '0;
            psum_reg  <= '0;
            hsum_reg  <= '0;
            msum_reg  <= '0;
        end
    end

    // Four lanes stepped together
    psa_div_lane u_div_temp (
        .aclk     (aclk),
        .load     (cmd.div_load),
        .step     (cmd.div_step),
        .dividend ({{(DVD_W-TSUM_W){1'b0}}, tsum_abs}),
        .divisor  (count_reg),
        .quotient (q_temp)
    );

    psa_div_lane u_div_pres (
        .aclk     (aclk),
        .load     (cmd.div_load),
        .step     (cmd.div_step),
        .dividend (psum_reg),
        .divisor  (count_reg),
        .quotient (q_pres)
    );

    psa_div_lane u_div_hum (
        .aclk     (aclk),
        .load     (cmd.div_load),
        .step     (cmd.div_step),
        .dividend (hsum_reg),
        .divisor  (count_reg),
        .quotient (q_hum)
    );

    psa_div_lane u_div_moist (
        .aclk     (aclk),
        .load     (cmd.div_load),
        .step     (cmd.div_step),
        .dividend ({{(DVD_W-MSUM_W){1'b0}}, msum_reg}),
        .divisor  (count_reg),
        .quotient (q_moist)
    );

    // Restore the sign of the temperature mean, truncating toward zero
    assign avg_temp = neg_reg ? (~q_temp[TEMP_W-1:0] + 1'b1) : q_temp[TEMP_W-1:0];
    assign has_avg  = report_fire_reg && !empty_reg;

    assign status.report_fire = report_fire_reg;
    assign status.count_zero  = (count_reg == '0);

    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

endmodule

@@ rtl/periodic_sensor_averager_top.sv @@
// Top level of the periodic sensor averager: controller, datapath and port wiring.
// Depends on psa_pkg, psa_ctrl and psa_dpath.
//
// Usage:
//   s_* carries one sensor word per millisecond tick (timestamp and four readings).
//   m_* returns exactly one result word per input word: flags in m_tuser, the
//   sample count and four averages in m_tdata (all zero unless a non-empty report closed).
//   cfg_* writes the sample interval (index 0) or report interval (index 1);
//   cfg_ready is always high and any such write restarts the run. Write only
//   while the block is idle.
// Sequence:
//   A word that does not close a report passes through capture, timer and
//   accumulate before its result enters the output register, once that is free;
//   a reporting word adds a load step and 33 divider steps (one quotient bit per
//   cycle in four parallel lanes), or the load step alone for an empty report.
//   s_tready rises again as the result is registered: one word at a time.
// Reset (aresetn low, synchronous) restores the default intervals, clears the
// run and empties the output. While the receiver stalls, the result is held in
// the output register and one further word may be processed up to its result.
module periodic_sensor_averager_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // now_ms[31:0], temperature[46:32], pressure_pa[63:47], humidity[80:64],
    // moisture_raw[93:81], zero fill[95:94]
    input  logic [psa_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // sample_count[15:0], avg_temperature[30:16], avg_pressure[47:31],
    // avg_humidity[64:48], avg_moisture[77:65], zero fill[79:78]
    output logic [psa_pkg::M_TDATA_W-1:0]  m_tdata,
    // report_valid[0], sampled[1], empty_report[2]
    output logic [psa_pkg::M_TUSER_W-1:0]  m_tuser,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [psa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [psa_pkg::CFG_DAT_W-1:0]  cfg_data
);
    import psa_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    psa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    psa_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

`ifndef SYNTHESIS
    // One word at a time: acceptance closes the input until the result is registered
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a word is in progress");

    // An empty report is always a report
    a_empty_is_report: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tuser[2] || m_tuser[0]))
        else $error("empty_report without report_valid");

    // Averages and count are zero unless a non-empty report closed
    a_zero_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (!m_tuser[0] || m_tuser[2])) |-> (m_tdata == '0))
        else $error("non-zero result data outside a non-empty report");
`endif

endmodule

@@ verif/periodic_sensor_averager_top_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of periodic_sensor_averager_top: a tracker class predicts one
// result word per sensor word and compares every returned word field by field.
// Depends on psa_pkg and the RTL of periodic_sensor_averager_top.

class averager_tracker;

    typedef struct packed {
        bit        report_valid;
        bit        sampled;
        bit        empty_report;
        bit [15:0] sample_count;
        bit [14:0] avg_temperature;
        bit [16:0] avg_pressure;
        bit [16:0] avg_humidity;
        bit [12:0] avg_moisture;
    } tick_result_t;

    // Register copies
    bit [31:0]       sample_period;
    bit [31:0]       report_period;

    // Timer and accumulator copies
    bit [31:0]       sample_origin;
    bit [31:0]       report_origin;
    bit              aligned;
    int unsigned     samples;
    longint          temp_acc;
    longint unsigned pres_acc;
    longint unsigned hum_acc;
    longint unsigned moist_acc;

    tick_result_t    due_results[$];
    int              errors;

    function new();
        sample_period = psa_pkg::SAMPLE_INT_RST;
        report_period = psa_pkg::REPORT_INT_RST;
        sample_origin = '0;
        report_origin = '0;
        errors        = 0;
        restart_run();
    endfunction

    // Drop the running sums and re-align both timers on the next word
    function void restart_run();
        aligned   = 1'b0;
        samples   = 0;
        temp_acc  = 0;
        pres_acc  = 0;
        hum_acc   = 0;
        moist_acc = 0;
    endfunction

    function void set_register(bit [1:0] idx, bit [31:0] value);
        case (idx)
            psa_pkg::REG_SAMPLE_INTERVAL: begin
                sample_period = value;
                restart_run();
            end
            psa_pkg::REG_REPORT_INTERVAL: begin
                report_period = value;
                restart_run();
            end
            default: ;
        endcase
    endfunction

    // Due once the elapsed time reaches the period; the new origin never lags now
    function bit timer_due(input bit [31:0] origin, input bit [31:0] period,
                           input bit [31:0] now, output bit [31:0] next_origin);
        bit [31:0] elapsed;
        bit [31:0] adv;
        elapsed     = now - origin;
        adv         = origin + period;
        next_origin = origin;
        if (elapsed >= period) begin
            next_origin = (adv < now) ? now : adv;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Work out the result word that one accepted sensor word causes
    function void take_word(bit [95:0] w);
        tick_result_t     r;
        bit [31:0]        now;
        bit signed [14:0] temp;
        bit [16:0]        pres;
        bit [16:0]        hum;
        bit [12:0]        moist_raw;
        bit [12:0]        moist;
        bit [31:0]        next;
        longint           n_s;
        longint unsigned  n_u;
        now       = w[31:0];
        temp      = w[46:32];
        pres      = w[63:47];
        hum       = w[80:64];
        moist_raw = w[93:81];
        // readings above 1.0 clamp, so the inverted term bottoms out at zero
        moist = (moist_raw > psa_pkg::MOIST_ONE) ? 13'd0 : psa_pkg::MOIST_ONE - moist_raw;
        r     = '0;

        if (!aligned) begin
            sample_origin = now;
            report_origin = now;
            aligned       = 1'b1;
        end

        // sample step first; a full count drops the readings but the timer still moves
        if (timer_due(sample_origin, sample_period, now, next)) begin
            if (samples < psa_pkg::MAX_SAMPLES) begin
                temp_acc  += temp;
                pres_acc  += pres;
                hum_acc   += hum;
                moist_acc += moist;
                samples++;
                r.sampled = 1'b1;
            end
        end
        sample_origin = next;

        // report step on the same timestamp
        if (timer_due(report_origin, report_period, now, next)) begin
            r.report_valid = 1'b1;
            if (samples == 0) begin
                r.empty_report = 1'b1;
            end else begin
                n_s               = samples;
                n_u               = samples;
                r.sample_count    = samples[15:0];
                r.avg_temperature = 15'(temp_acc / n_s);
                r.avg_pressure    = 17'(pres_acc / n_u);
                r.avg_humidity    = 17'(hum_acc / n_u);
                r.avg_moisture    = 13'(moist_acc / n_u);
            end
            samples   = 0;
            temp_acc  = 0;
            pres_acc  = 0;
            hum_acc   = 0;
            moist_acc = 0;
        end
        report_origin = next;

        due_results.push_back(r);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            errors++;
            $error("%s: expected %0h, got %0h", name, want, got);
        end
    endfunction

    // Compare a returned word with the oldest outstanding prediction
    function void compare_result(logic [79:0] d, logic [2:0] u);
        tick_result_t e;
        if (due_results.size() == 0) begin
            errors++;
            $error("result word with no sensor word outstanding: tdata %h, tuser %h", d, u);
            return;
        end
        e = due_results.pop_front();
        check_field("report_valid",    32'(e.report_valid),    32'(u[0]));
        check_field("sampled",         32'(e.sampled),         32'(u[1]));
        check_field("empty_report",    32'(e.empty_report),    32'(u[2]));
        check_field("sample_count",    32'(e.sample_count),    32'(d[15:0]));
        check_field("avg_temperature", 32'(e.avg_temperature), 32'(d[30:16]));
        check_field("avg_pressure",    32'(e.avg_pressure),    32'(d[47:31]));
        check_field("avg_humidity",    32'(e.avg_humidity),    32'(d[64:48]));
        check_field("avg_moisture",    32'(e.avg_moisture),    32'(d[77:65]));
    endfunction

    function int pending();
        return due_results.size();
    endfunction

endclass

module periodic_sensor_averager_top_tb;

    import psa_pkg::*;

    localparam int IDLE_LIMIT     = 2000;
    localparam int SETTLE_CYCLES  = 50;
    localparam int RANDOM_WORDS   = 1000;

    // Unused register indexes, written to show they are ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DAT_W-1:0]  cfg_data;

    averager_tracker       tracker;
    bit                    calm;
    int unsigned           idle_cycles;

    periodic_sensor_averager_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Pack one sensor word, lowest field first
    function automatic logic [S_TDATA_W-1:0] sensor_word(logic [31:0] now, logic [14:0] temp,
                                                         logic [16:0] pres, logic [16:0] hum,
                                                         logic [12:0] moist);
        return {2'b00, moist, hum, pres, temp, now};
    endfunction

    // Mostly plausible readings, a quarter of them raw bits across the whole field
    function automatic logic [S_TDATA_W-1:0] random_word(logic [31:0] now);
        logic [14:0] t;
        logic [16:0] p;
        logic [16:0] h;
        logic [12:0] m;
        int          tv;
        if ($urandom_range(0, 3) == 0) begin
            t = 15'($urandom);
            p = 17'($urandom);
            h = 17'($urandom);
            m = 13'($urandom);
        end else begin
            tv = int'($urandom_range(0, 12500)) - 4000;
            t  = tv[14:0];
            p  = 17'($urandom_range(30000, 110000));
            h  = 17'($urandom_range(0, 102400));
            m  = 13'($urandom_range(0, 4096));
        end
        return sensor_word(now, t, p, h, m);
    endfunction

    // Present one word after a random gap and hold it until accepted
    task automatic send_word(input logic [S_TDATA_W-1:0] w);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do @(posedge aclk); while (s_tready !== 1'b1);
        tracker.take_word(w);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        tracker.set_register(idx, value);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Stop sending, drain every outstanding result and let the pipeline go quiet
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Receiver: random stall before each word, none while calm
    initial begin
        int stall;
        m_tready <= 1'b0;
        forever begin
            stall = calm ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                @(negedge aclk);
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
            @(negedge aclk);
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
        end
    end

    // Check each accepted result word
    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
            tracker.compare_result(m_tdata, m_tuser);
    end

    // Watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("periodic_sensor_averager_top_tb NOT OK");
            $finish;
        end
    end

    initial begin
        logic [31:0] now;
        logic [31:0] sp;
        logic [31:0] rp;
        int          span;
        int          words;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        cfg_valid   <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        aresetn     <= 1'b0;
        idle_cycles <= 0;
        calm        = 1'b0;
        tracker     = new();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Default intervals, timestamps straddling the 2^32 wrap
        now = 32'hFFFF_FC00;
        send_word(random_word(now));            // aligns both timers, nothing due
        send_word(random_word(now + 999));      // one tick short of a sample
        send_word(random_word(now + 1000));     // first sample, just short of the wrap
        send_word(random_word(now + 2500));     // sample, origin clamps to now
        send_word(random_word(now + 60000));    // sample and report
        send_word(random_word(now + 200000));   // long jump: both origins clamp to now
        send_word(random_word(now + 200001));
        settle();

        // Unused indexes leave the run alone
        write_reg(REG_SPARE_A, $urandom);
        write_reg(REG_SPARE_B, $urandom);
        send_word(random_word(now + 260001));
        settle();

        // Zero periods: every word samples and reports its own readings
        write_reg(REG_SAMPLE_INTERVAL, 32'd0);
        write_reg(REG_REPORT_INTERVAL, 32'd0);
        send_word(sensor_word(32'd0, 15'h4000, 17'd0, 17'd0, 13'd0));
        send_word(sensor_word(32'd1, 15'h3FFF, 17'h1FFFF, 17'h1FFFF, 13'd4096));
        send_word(sensor_word(32'd1, 15'h7FFF, 17'd30000, 17'd102400, 13'd4097));
        send_word(sensor_word(32'hFFFF_FFFF, 15'd0, 17'd110000, 17'd1, 13'h1FFF));
        // -40.00 C and 85.00 C
        send_word(sensor_word(32'h8000_0000, 15'h7060, 17'd65536, 17'd65536, 13'd1));
        send_word(sensor_word(32'h8000_0001, 15'h2134, 17'd1, 17'd0, 13'd4095));
        settle();

        // Sample period at its maximum: empty reports until the start comes round
        write_reg(REG_SAMPLE_INTERVAL, 32'hFFFF_FFFF);
        send_word(random_word(32'd100));
        send_word(random_word(32'd100));
        send_word(random_word(32'd99));
        settle();

        // Report period at its maximum, due one tick before the origin again
        write_reg(REG_SAMPLE_INTERVAL, 32'd0);
        write_reg(REG_REPORT_INTERVAL, 32'hFFFF_FFFF);
        send_word(random_word(32'd5));
        send_word(random_word(32'd5000));
        send_word(random_word(32'd4));
        settle();

        // Random phases: short periods so samples and reports come often
        words = 0;
        while (words < RANDOM_WORDS) begin
            calm = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 7))
                0:       sp = 32'd0;
                1:       sp = 32'hFFFF_FFFF;
                2, 3:    sp = $urandom_range(1, 5);
                default: sp = $urandom_range(1, 40);
            endcase
            case ($urandom_range(0, 7))
                0:       rp = 32'd0;
                1:       rp = 32'hFFFF_FFFF;
                default: rp = $urandom_range(1, 300);
            endcase
            if ($urandom_range(0, 4) != 0)
                write_reg(REG_SAMPLE_INTERVAL, sp);
            if ($urandom_range(0, 4) != 0)
                write_reg(REG_REPORT_INTERVAL, rp);
            if ($urandom_range(0, 5) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom);

            now  = $urandom;
            span = $urandom_range(20, 80);
            for (int i = 0; i < span; i++) begin
                // mostly forward steps; now and then a jump anywhere or a step back
                case ($urandom_range(0, 19))
                    0:       now = $urandom;
                    1:       now = now - $urandom_range(1, 50);
                    default: now = now + $urandom_range(0, 60);
                endcase
                send_word(random_word(now));
            end
            words += span;
            settle();
        end

        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("periodic_sensor_averager_top_tb OK");
        else
            $display("periodic_sensor_averager_top_tb NOT OK");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/psa_pkg.sv
rtl/psa_div_lane.sv
rtl/psa_ctrl.sv
rtl/psa_dpath.sv
rtl/periodic_sensor_averager_top.sv
verif/periodic_sensor_averager_top_tb.sv
